>>> rtl/cbo_pkg.sv
// ----------------------------------------------------------------------------
// cbo_pkg
// shared types, register indexes and constants of the caption band overlay
// compositor
// ----------------------------------------------------------------------------
package cbo_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int DIM_W      = 12;
  localparam int PCT_W      = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH    = 3'd0,
    REG_IMAGE_HEIGHT   = 3'd1,
    REG_CAPTION_WIDTH  = 3'd2,
    REG_CAPTION_HEIGHT = 3'd3,
    REG_PREVIEW_MODE   = 3'd4,
    REG_SEARCH_PERCENT = 3'd5
  } cfg_reg_t;

  // register reset values
  localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH    = 12'd640;
  localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT   = 12'd480;
  localparam logic [PCT_W-1:0] RST_SEARCH_PERCENT = 7'd50;

  // caption padding
  localparam int PAD_W = 5;
  localparam logic [PAD_W-1:0] PAD_PREVIEW = 5'd6;
  localparam logic [PAD_W-1:0] PAD_NORMAL  = 5'd24;

  // square side: min(w,h) * percent / 100, the divide done as a reciprocal
  localparam int PROD_W      = DIM_W + PCT_W;
  localparam int RECIP_W     = 20;
  localparam int RECIP_SHIFT = 26;
  localparam logic [RECIP_W-1:0] RECIP_100 = 20'd671089;
  localparam int SIDE_W      = 13;

  // signed width of bracket corner coordinates
  localparam int GEO_W = 15;

  // geometry pipeline depth after a register write
  localparam int GEOM_LAG = 3;
  localparam int SETTLE_W = $clog2(GEOM_LAG + 1);

  // bracket shape
  localparam int BRACKET_LENGTH    = 14;
  localparam int BRACKET_THICKNESS = 2;

  // colors
  localparam logic [7:0] MARK_RED   = 8'd80;
  localparam logic [7:0] MARK_GREEN = 8'd255;
  localparam logic [7:0] MARK_BLUE  = 8'd140;
  localparam logic [7:0] FULL_ALPHA = 8'd255;

  // band dimming 3/10: (3*c)*205 >> 11 is exact for 3*c below 1020
  localparam int DIM_PROD_W = 18;
  localparam int DIM_SHIFT  = 11;
  localparam logic [DIM_PROD_W-1:0] DIM_MUL = 18'd615;

  typedef struct packed {
    logic [7:0] src_red;
    logic [7:0] src_green;
    logic [7:0] src_blue;
    logic [7:0] cap_red;
    logic [7:0] cap_green;
    logic [7:0] cap_blue;
    logic [7:0] cap_alpha;
  } in_pix_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } out_pix_t;

  // frame geometry derived from the registers
  typedef struct packed {
    logic [DIM_W-1:0]        width;
    logic [DIM_W-1:0]        height;
    logic                    preview;
    logic [PAD_W-1:0]        pad;
    logic [DIM_W-1:0]        band;
    logic [DIM_W:0]          top;
    logic [DIM_W+1:0]        top_end;
    logic [DIM_W:0]          cap_x_end;
    logic signed [GEO_W-1:0] x0;
    logic signed [GEO_W-1:0] x1;
    logic signed [GEO_W-1:0] y0;
    logic signed [GEO_W-1:0] y1;
    logic                    busy;
  } geom_t;

  // truncated 3/10 of a color channel
  function automatic logic [7:0] dim_scale(input logic [7:0] c);
    logic [DIM_PROD_W-1:0] p;
    p = DIM_PROD_W'(c) * DIM_MUL;
    return 8'(p >> DIM_SHIFT);
  endfunction

endpackage

>>> rtl/cbo_geometry.sv
// ----------------------------------------------------------------------------
// cbo_geometry
// configuration registers and the registered frame geometry derived from
// them; flags busy after reset and while a register write works through the pipeline
// ----------------------------------------------------------------------------
module cbo_geometry
  import cbo_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output geom_t                 geom
);

  logic [DIM_W-1:0]  image_width;
  logic [DIM_W-1:0]  image_height;
  logic [DIM_W-1:0]  caption_width;
  logic [DIM_W-1:0]  caption_height;
  logic              preview_mode;
  logic [PCT_W-1:0]  search_percent;
  logic [SETTLE_W-1:0] settle;

  // first stage
  logic [PAD_W-1:0]  pad;
  logic [DIM_W-1:0]  band;
  logic [DIM_W:0]    top;
  logic [DIM_W+1:0]  top_end;
  logic [DIM_W:0]    cap_x_end;
  logic [PROD_W-1:0] prod;
  // second stage
  logic [SIDE_W-1:0] side;
  // third stage
  logic signed [GEO_W-1:0] x0, x1, y0, y1;

  logic [PAD_W-1:0]  pad_next;
  logic [DIM_W:0]    need_next;
  logic [DIM_W-1:0]  band_next;
  logic [DIM_W:0]    top_next;
  logic [DIM_W-1:0]  min_dim;
  logic [PROD_W+RECIP_W-1:0] side_full;
  logic signed [GEO_W-1:0] dx, dy, dx_adj, dy_adj, x0_next, y0_next;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= RST_IMAGE_WIDTH;
      image_height   <= RST_IMAGE_HEIGHT;
      caption_width  <= '0;
      caption_height <= '0;
      preview_mode   <= 1'b0;
      search_percent <= RST_SEARCH_PERCENT;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:    image_width    <= cfg_data;
        REG_IMAGE_HEIGHT:   image_height   <= cfg_data;
        REG_CAPTION_WIDTH:  caption_width  <= cfg_data;
        REG_CAPTION_HEIGHT: caption_height <= cfg_data;
        REG_PREVIEW_MODE:   preview_mode   <= cfg_data[0];
        REG_SEARCH_PERCENT: search_percent <= cfg_data[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // settle count: geometry is stale until the pipeline has refilled
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      settle <= SETTLE_W'(GEOM_LAG);
    end else if (settle != '0) begin
      settle <= settle - 1'b1;
    end
  end

  // band and caption window
  always_comb begin
    pad_next  = preview_mode ? PAD_PREVIEW : PAD_NORMAL;
    need_next = (DIM_W+1)'(caption_height) + ((DIM_W+1)'(pad_next) << 1);
    band_next = (need_next < (DIM_W+1)'(image_height)) ?
                DIM_W'((DIM_W+1)'(image_height) - need_next) : '0;
    top_next  = (DIM_W+1)'(band_next) + (DIM_W+1)'(pad_next);
    min_dim   = (image_width < image_height) ? image_width : image_height;
  end

  always_ff @(posedge clk) begin
    pad       <= pad_next;
    band      <= band_next;
    top       <= top_next;
    top_end   <= (DIM_W+2)'(top_next) + (DIM_W+2)'(caption_height);
    cap_x_end <= (DIM_W+1)'(pad_next) + (DIM_W+1)'(caption_width);
    prod      <= PROD_W'(min_dim) * PROD_W'(search_percent);
  end

  // square side by reciprocal multiply
  assign side_full = (PROD_W+RECIP_W)'(prod) * (PROD_W+RECIP_W)'(RECIP_100);

  always_ff @(posedge clk) begin
    side <= SIDE_W'(side_full >> RECIP_SHIFT);
  end

  // corner positions, halves truncated toward zero
  always_comb begin
    dx      = $signed(GEO_W'(image_width)) - $signed(GEO_W'(side));
    dy      = $signed(GEO_W'(image_height)) - $signed(GEO_W'(side));
    dx_adj  = dx + (dx[GEO_W-1] ? GEO_W'(1) : GEO_W'(0));
    dy_adj  = dy + (dy[GEO_W-1] ? GEO_W'(1) : GEO_W'(0));
    x0_next = dx_adj >>> 1;
    y0_next = dy_adj >>> 1;
  end

  always_ff @(posedge clk) begin
    x0 <= x0_next;
    y0 <= y0_next;
    x1 <= x0_next + $signed(GEO_W'(side)) - $signed(GEO_W'(1));
    y1 <= y0_next + $signed(GEO_W'(side)) - $signed(GEO_W'(1));
  end

  always_comb begin
    geom.width     = image_width;
    geom.height    = image_height;
    geom.preview   = preview_mode;
    geom.pad       = pad;
    geom.band      = band;
    geom.top       = top;
    geom.top_end   = top_end;
    geom.cap_x_end = cap_x_end;
    geom.x0        = x0;
    geom.x1        = x1;
    geom.y0        = y0;
    geom.y1        = y1;
    geom.busy      = (settle != '0);
  end

endmodule

>>> rtl/cbo_compose.sv
// ----------------------------------------------------------------------------
// cbo_compose
// per-pixel composition: band dimming, caption copy and preview brackets
// ----------------------------------------------------------------------------
module cbo_compose
  import cbo_pkg::*;
#(
  parameter int MAX_DIM_BITS = 12
) (
  input  in_pix_t                 pix,
  input  logic [MAX_DIM_BITS-1:0] x,
  input  logic [MAX_DIM_BITS-1:0] y,
  input  geom_t                   geom,
  output out_pix_t                result
);

  localparam int CMP_W = ((MAX_DIM_BITS > GEO_W) ? MAX_DIM_BITS : GEO_W) + 2;

  logic signed [CMP_W-1:0] xs, ys, du0, du1, dv0, dv1;
  logic in_band, in_caption, on_bracket;

  function automatic logic in_bar(input logic signed [CMP_W-1:0] u,
                                  input logic signed [CMP_W-1:0] v);
    return (u >= 0) && (u < CMP_W'(BRACKET_LENGTH)) &&
           (v >= 0) && (v < CMP_W'(BRACKET_THICKNESS));
  endfunction

  function automatic logic corner(input logic signed [CMP_W-1:0] u,
                                  input logic signed [CMP_W-1:0] v);
    return in_bar(u, v) || in_bar(v, u);
  endfunction

  // position tests
  always_comb begin
    xs  = $signed(CMP_W'(x));
    ys  = $signed(CMP_W'(y));
    du0 = xs - geom.x0;
    du1 = geom.x1 - xs;
    dv0 = ys - geom.y0;
    dv1 = geom.y1 - ys;

    in_band = ys >= $signed(CMP_W'(geom.band));

    in_caption = (ys >= $signed(CMP_W'(geom.top))) &&
                 (ys < $signed(CMP_W'(geom.top_end))) &&
                 (ys < $signed(CMP_W'(geom.height))) &&
                 (xs >= $signed(CMP_W'(geom.pad))) &&
                 (xs < $signed(CMP_W'(geom.cap_x_end))) &&
                 (xs < $signed(CMP_W'(geom.width))) &&
                 (pix.cap_alpha != '0);

    on_bracket = geom.preview &&
                 (corner(du0, dv0) || corner(du1, dv0) ||
                  corner(du1, dv1) || corner(du0, dv1));
  end

  // layer selection, brackets on top
  always_comb begin
    if (on_bracket) begin
      result = '{red: MARK_RED, green: MARK_GREEN, blue: MARK_BLUE,
                 alpha: FULL_ALPHA};
    end else if (in_caption) begin
      result = '{red: pix.cap_red, green: pix.cap_green, blue: pix.cap_blue,
                 alpha: pix.cap_alpha};
    end else if (in_band) begin
      result = '{red: dim_scale(pix.src_red), green: dim_scale(pix.src_green),
                 blue: dim_scale(pix.src_blue), alpha: FULL_ALPHA};
    end else begin
      result = '{red: pix.src_red, green: pix.src_green, blue: pix.src_blue,
                 alpha: FULL_ALPHA};
    end
  end

endmodule

>>> rtl/caption_band_overlay_compositor.sv
// ----------------------------------------------------------------------------
// caption_band_overlay_compositor
// composes RGB raster pixels with a dimmed caption band, an aligned caption
// bitmap and optional preview brackets into RGBA pixels
// ----------------------------------------------------------------------------
// usage
//   input channel: one request per pixel in raster order (in_valid/in_stall),
//   source RGB plus the caption RGBA already aligned to that position
//   output channel: one request per pixel (out_valid/out_stall), RGBA and
//   frame_end on the last pixel of the frame
//   pixels pass an input register, then the composition logic into the output
//   register; one pixel per clock sustained while out_stall and busy are low
//   the output register and the input register form a two-entry pipe, so a
//   new pixel is still taken while a finished one waits to be taken
//   a stalled result holds; the input stalls when both stages are full and
//   out_stall is high, and after reset and each register write while the
//   three-stage geometry pipeline (band, reciprocal divide for the bracket
//   square, corner positions) settles; register writes go through it
//   reset clears the raster counters, the pipe and restores register
//   defaults; write registers only while no pixel is in flight
// ----------------------------------------------------------------------------
module caption_band_overlay_compositor
  import cbo_pkg::*;
#(
  parameter int MAX_DIM_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input pixels
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            src_red,
  input  logic [7:0]            src_green,
  input  logic [7:0]            src_blue,
  input  logic [7:0]            cap_red,
  input  logic [7:0]            cap_green,
  input  logic [7:0]            cap_blue,
  input  logic [7:0]            cap_alpha,
  // output pixels
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue,
  output logic [7:0]            out_alpha,
  output logic                  frame_end
);

  localparam int CNT_CMP_W = ((MAX_DIM_BITS > DIM_W) ? MAX_DIM_BITS : DIM_W) + 1;

  geom_t    geom;
  out_pix_t comp;

  logic [MAX_DIM_BITS-1:0] column_count, row_count;
  logic [MAX_DIM_BITS-1:0] column_count_next, row_count_next;
  logic row_end, last_pixel;

  logic                    s1_valid;
  in_pix_t                 s1_pix;
  logic [MAX_DIM_BITS-1:0] s1_x, s1_y;
  logic                    s1_frame_end;

  logic out_load, in_accept;

  cbo_geometry u_geometry (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom)
  );

  // handshake
  assign out_load  = !out_valid || !out_stall;
  assign in_stall  = geom.busy || (s1_valid && !out_load);
  assign in_accept = in_valid && !in_stall;

  // raster position
  always_comb begin
    row_end    = (CNT_CMP_W'(column_count) + 1'b1) >= CNT_CMP_W'(geom.width);
    last_pixel = row_end && ((CNT_CMP_W'(row_count) + 1'b1) >= CNT_CMP_W'(geom.height));
    if (row_end) begin
      column_count_next = '0;
      row_count_next    = last_pixel ? '0 : row_count + 1'b1;
    end else begin
      column_count_next = column_count + 1'b1;
      row_count_next    = row_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // pipe valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (out_load) begin
        s1_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= s1_valid;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pix       <= '{src_red: src_red, src_green: src_green, src_blue: src_blue,
                        cap_red: cap_red, cap_green: cap_green, cap_blue: cap_blue,
                        cap_alpha: cap_alpha};
      s1_x         <= column_count;
      s1_y         <= row_count;
      s1_frame_end <= last_pixel;
    end
  end

  cbo_compose #(
    .MAX_DIM_BITS (MAX_DIM_BITS)
  ) u_compose (
    .pix    (s1_pix),
    .x      (s1_x),
    .y      (s1_y),
    .geom   (geom),
    .result (comp)
  );

  // output register
  always_ff @(posedge clk) begin
    if (out_load && s1_valid) begin
      out_red   <= comp.red;
      out_green <= comp.green;
      out_blue  <= comp.blue;
      out_alpha <= comp.alpha;
      frame_end <= s1_frame_end;
    end
  end

endmodule

>>> rtl/cbo_checker.sv
// ----------------------------------------------------------------------------
// cbo_checker
// port-level checks of the compositor, bound to the top level
// ----------------------------------------------------------------------------
module cbo_checker (
  input logic       clk,
  input logic       rst,
  input logic       cfg_write,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic [7:0] out_alpha,
  input logic       frame_end
);

  // leaving reset: pipe empty and input held off while geometry settles
  assert property (@(posedge clk) (!rst && $past(rst)) |-> (in_stall && !out_valid))
    else $error("pipe not empty or input open right after reset");

  // a register write holds off new pixels on the next cycle
  assert property (@(posedge clk) disable iff (rst) cfg_write |=> in_stall)
    else $error("input open right after a register write");

  // a stalled result holds its value
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_red) &&
      $stable(out_green) && $stable(out_blue) && $stable(out_alpha) &&
      $stable(frame_end)))
    else $error("stalled result changed");

endmodule

bind caption_band_overlay_compositor cbo_checker u_checker (.*);

>>> tb/tb_caption_band_overlay_compositor.sv
// ----------------------------------------------------------------------------
// tb_caption_band_overlay_compositor
// self-checking bench: a short table of directed pixels and register writes,
// then randomized frames in preview and normal mode plus degenerate sizes;
// every output pixel is checked field by field against a given result or a
// behavioral copy of the compositor kept inside the bench
// ----------------------------------------------------------------------------
module tb_caption_band_overlay_compositor;
  timeunit 1ns;
  timeprecision 1ps;
  import cbo_pkg::*;

  localparam int DIM_NUM     = 3;
  localparam int DIM_DEN     = 10;
  localparam int PERCENT_DEN = 100;
  localparam int DIM_MASK    = (1 << DIM_W) - 1;
  localparam int HOLD_LONG   = 64;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef enum logic {ROW_WRITE, ROW_PIXEL} row_kind_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       frame_end;
  } pixel_result_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    in_pix_t               pix;
    logic                  typed;
    pixel_result_t         result;
  } stim_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [7:0]            src_red;
  logic [7:0]            src_green;
  logic [7:0]            src_blue;
  logic [7:0]            cap_red;
  logic [7:0]            cap_green;
  logic [7:0]            cap_blue;
  logic [7:0]            cap_alpha;
  logic                  out_valid;
  logic                  out_stall;
  logic [7:0]            out_red;
  logic [7:0]            out_green;
  logic [7:0]            out_blue;
  logic [7:0]            out_alpha;
  logic                  frame_end;

  // bench copy of the registers and raster counters
  int img_width;
  int img_height;
  int cap_width;
  int cap_height;
  bit preview_on;
  int percent;
  int col_pos;
  int row_pos;

  pixel_result_t expected_pixels[$];
  stim_row_t     directed_rows[$];
  int            mismatch_count = 0;
  int            sent_count     = 0;
  bit            send_idle      = 1'b1;
  bit            recv_idle      = 1'b1;
  int            long_hold      = 0;

  caption_band_overlay_compositor uut (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one bracket corner: a horizontal and a vertical bar opening inward
  function automatic bit near_corner(int x, int y, int ax, int ay, int dx, int dy);
    int u;
    int v;
    u = (x - ax) * dx;
    v = (y - ay) * dy;
    return (u >= 0 && u < BRACKET_LENGTH && v >= 0 && v < BRACKET_THICKNESS) ||
           (v >= 0 && v < BRACKET_LENGTH && u >= 0 && u < BRACKET_THICKNESS);
  endfunction

  function automatic bit on_bracket(int x, int y);
    int side;
    int x0;
    int y0;
    int x1;
    int y1;
    side = (img_width < img_height) ? img_width : img_height;
    side = side * percent / PERCENT_DEN;
    x0 = (img_width - side) / 2;
    y0 = (img_height - side) / 2;
    x1 = x0 + side - 1;
    y1 = y0 + side - 1;
    return near_corner(x, y, x0, y0, 1, 1) || near_corner(x, y, x1, y0, -1, 1) ||
           near_corner(x, y, x1, y1, -1, -1) || near_corner(x, y, x0, y1, 1, -1);
  endfunction

  // composed pixel for the current raster position, then advance the counters
  function automatic pixel_result_t compose_pixel(in_pix_t pix);
    pixel_result_t res;
    int pad;
    int band;
    int top;
    bit row_end;
    pad = preview_on ? int'(PAD_PREVIEW) : int'(PAD_NORMAL);
    band = (cap_height + 2 * pad < img_height) ? img_height - cap_height - 2 * pad : 0;
    res.red   = pix.src_red;
    res.green = pix.src_green;
    res.blue  = pix.src_blue;
    res.alpha = FULL_ALPHA;
    // dimmed band from the band row down
    if (row_pos >= band) begin
      res.red   = 8'(int'(pix.src_red) * DIM_NUM / DIM_DEN);
      res.green = 8'(int'(pix.src_green) * DIM_NUM / DIM_DEN);
      res.blue  = 8'(int'(pix.src_blue) * DIM_NUM / DIM_DEN);
    end
    // caption window, clipped to the frame
    top = band + pad;
    if (row_pos >= top && row_pos < top + cap_height && row_pos < img_height &&
        col_pos >= pad && col_pos < pad + cap_width && col_pos < img_width &&
        pix.cap_alpha != 8'd0) begin
      res.red   = pix.cap_red;
      res.green = pix.cap_green;
      res.blue  = pix.cap_blue;
      res.alpha = pix.cap_alpha;
    end
    // preview brackets on top of everything
    if (preview_on && on_bracket(col_pos, row_pos)) begin
      res.red   = MARK_RED;
      res.green = MARK_GREEN;
      res.blue  = MARK_BLUE;
      res.alpha = FULL_ALPHA;
    end
    // raster counters
    row_end = (col_pos + 1 >= img_width);
    res.frame_end = row_end && (row_pos + 1 >= img_height);
    if (row_end) begin
      col_pos = 0;
      row_pos = res.frame_end ? 0 : ((row_pos + 1) & DIM_MASK);
    end else begin
      col_pos = (col_pos + 1) & DIM_MASK;
    end
    return res;
  endfunction

  function automatic int draw_wait(bit idle_on);
    return idle_on ? int'($urandom_range(0, 19)) : 0;
  endfunction

  function automatic in_pix_t random_pixel();
    in_pix_t pix;
    int sel;
    pix.src_red   = 8'($urandom);
    pix.src_green = 8'($urandom);
    pix.src_blue  = 8'($urandom);
    pix.cap_red   = 8'($urandom);
    pix.cap_green = 8'($urandom);
    pix.cap_blue  = 8'($urandom);
    sel = $urandom_range(0, 5);
    if (sel < 2) begin
      pix.cap_alpha = 8'd0;
    end else if (sel == 2) begin
      pix.cap_alpha = 8'd255;
    end else begin
      pix.cap_alpha = 8'($urandom);
    end
    return pix;
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 1;
      2: return DIM_MASK;
      default: return $urandom_range(2, DIM_MASK - 1);
    endcase
  endfunction

  function automatic int pick_percent();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 100;
      2: return 127;
      default: return $urandom_range(0, 127);
    endcase
  endfunction

  function automatic void row_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r = '0;
    r.kind  = ROW_WRITE;
    r.index = idx;
    r.data  = data;
    directed_rows.push_back(r);
  endfunction

  function automatic void row_pixel(in_pix_t pix, logic typed, pixel_result_t result);
    stim_row_t r;
    r = '0;
    r.kind   = ROW_PIXEL;
    r.pix    = pix;
    r.typed  = typed;
    r.result = result;
    directed_rows.push_back(r);
  endfunction

  // offer one request and keep it steady until taken
  task automatic offer_pixel(input in_pix_t pix, input logic typed,
                             input pixel_result_t typed_result);
    int gap;
    pixel_result_t predicted;
    gap = draw_wait(send_idle);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    src_red   <= pix.src_red;
    src_green <= pix.src_green;
    src_blue  <= pix.src_blue;
    cap_red   <= pix.cap_red;
    cap_green <= pix.cap_green;
    cap_blue  <= pix.cap_blue;
    cap_alpha <= pix.cap_alpha;
    in_valid  <= 1'b1;
    do @(posedge clk); while (in_stall);
    predicted = compose_pixel(pix);
    expected_pixels.push_back(typed ? typed_result : predicted);
    sent_count++;
  endtask

  task automatic offer_random_pixel();
    offer_pixel(random_pixel(), 1'b0, '0);
  endtask

  // run on to the end of the current frame
  task automatic finish_frame();
    do offer_random_pixel(); while (!(col_pos == 0 && row_pos == 0));
  endtask

  // stop sending and let every pixel in flight come out
  task automatic drain_pipe();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:    img_width  = int'(data);
      REG_IMAGE_HEIGHT:   img_height = int'(data);
      REG_CAPTION_WIDTH:  cap_width  = int'(data);
      REG_CAPTION_HEIGHT: cap_height = int'(data);
      REG_PREVIEW_MODE:   preview_on = data[0];
      REG_SEARCH_PERCENT: percent    = int'(data[PCT_W-1:0]);
      default: ;
    endcase
  endtask

  // full register set; unused upper bits of the narrow registers get noise
  task automatic set_frame(input int w, input int h, input int cw, input int ch,
                           input bit pv, input int pct);
    drain_pipe();
    write_register(REG_IMAGE_WIDTH, 12'(w));
    write_register(REG_IMAGE_HEIGHT, 12'(h));
    write_register(REG_CAPTION_WIDTH, 12'(cw));
    write_register(REG_CAPTION_HEIGHT, 12'(ch));
    write_register(REG_PREVIEW_MODE, {11'($urandom), pv});
    write_register(REG_SEARCH_PERCENT, {5'($urandom), 7'(pct)});
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // output side: random stall per pixel, one long hold on request
  initial begin : result_check
    pixel_result_t want;
    int hold;
    out_stall = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (long_hold > 0) begin
        hold = long_hold;
        long_hold = 0;
      end else begin
        hold = draw_wait(recv_idle);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      if (expected_pixels.size() == 0) begin
        $display("%0t ns: output pixel with no request waiting", $time);
        mismatch_count++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("out_red", want.red, out_red);
        check_field("out_green", want.green, out_green);
        check_field("out_blue", want.blue, out_blue);
        check_field("out_alpha", want.alpha, out_alpha);
        check_field("frame_end", want.frame_end, frame_end);
      end
      @(negedge clk);
    end
  end

  // stimulus
  initial begin : stimulus
    stim_row_t row;
    bit pipe_busy;
    int w;
    int h;
    int cw;
    int ch;
    int pick;
    int phase;
    int top;
    int waited;

    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    src_red   = '0;
    src_green = '0;
    src_blue  = '0;
    cap_red   = '0;
    cap_green = '0;
    cap_blue  = '0;
    cap_alpha = '0;
    img_width  = int'(RST_IMAGE_WIDTH);
    img_height = int'(RST_IMAGE_HEIGHT);
    cap_width  = 0;
    cap_height = 0;
    preview_on = 1'b0;
    percent    = int'(RST_SEARCH_PERCENT);
    col_pos    = 0;
    row_pos    = 0;

    // directed rows: defaults, writes to unused indexes, extremes of size
    row_write(REG_SPARE_A, 12'hFFF);
    row_write(REG_SPARE_B, 12'h000);
    row_pixel({8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255}, 1'b1,
              {8'd255, 8'd255, 8'd255, 8'd255, 1'b0});
    row_pixel({8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1,
              {8'd0, 8'd0, 8'd0, 8'd255, 1'b0});
    row_pixel({8'hA5, 8'h5A, 8'h3C, 8'h12, 8'h34, 8'h56, 8'h78}, 1'b0, '0);
    // one by one frame with the column already past the new width
    row_write(REG_IMAGE_WIDTH, 12'd1);
    row_write(REG_IMAGE_HEIGHT, 12'd1);
    row_pixel({8'd255, 8'd255, 8'd255, 8'd1, 8'd2, 8'd3, 8'd4}, 1'b1,
              {8'd76, 8'd76, 8'd76, 8'd255, 1'b1});
    row_pixel({8'd10, 8'd20, 8'd30, 8'd255, 8'd255, 8'd255, 8'd255}, 1'b1,
              {8'd3, 8'd6, 8'd9, 8'd255, 1'b1});
    // zero size: every pixel ends the frame
    row_write(REG_IMAGE_WIDTH, 12'd0);
    row_write(REG_IMAGE_HEIGHT, 12'd0);
    row_pixel({8'd100, 8'd200, 8'd50, 8'd9, 8'd9, 8'd9, 8'd9}, 1'b1,
              {8'd30, 8'd60, 8'd15, 8'd255, 1'b1});
    // largest sizes, percent over 100
    row_write(REG_IMAGE_WIDTH, 12'hFFF);
    row_write(REG_IMAGE_HEIGHT, 12'hFFF);
    row_write(REG_CAPTION_WIDTH, 12'hFFF);
    row_write(REG_CAPTION_HEIGHT, 12'hFFF);
    row_write(REG_PREVIEW_MODE, 12'd1);
    row_write(REG_SEARCH_PERCENT, 12'd127);
    row_pixel({8'hFF, 8'h00, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b0, '0);
    row_pixel({8'h01, 8'hFE, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h01}, 1'b0, '0);
    // zero side square
    row_write(REG_SEARCH_PERCENT, 12'd0);
    row_pixel({8'h33, 8'h66, 8'h99, 8'hCC, 8'h11, 8'h22, 8'h00}, 1'b0, '0);
    // tiny frame covered by brackets
    row_write(REG_IMAGE_WIDTH, 12'd4);
    row_write(REG_IMAGE_HEIGHT, 12'd3);
    row_write(REG_CAPTION_WIDTH, 12'd0);
    row_write(REG_CAPTION_HEIGHT, 12'd0);
    row_write(REG_SEARCH_PERCENT, 12'd100);
    for (int i = 0; i < 7; i++) begin
      row_pixel({8'(i * 37), 8'(255 - i * 29), 8'(i * 11), 8'hAA, 8'h55, 8'hF0,
                 8'(i * 40)}, 1'b0, '0);
    end

    // synchronous reset
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // walk the directed rows
    pipe_busy = 1'b0;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) begin
        if (pipe_busy) begin
          drain_pipe();
          pipe_busy = 1'b0;
        end
        write_register(row.index, row.data);
      end else begin
        offer_pixel(row.pix, row.typed, row.result);
        pipe_busy = 1'b1;
      end
    end

    // random frames
    phase = 0;
    while (sent_count < 750) begin
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 9);
      if (phase == 1) begin
        // back pressure: receiver holds off while the sender keeps going
        send_idle = 1'b0;
        pick = 9;
      end
      if (pick < 2) begin
        // degenerate or huge sizes, short noise burst
        set_frame(pick_extreme(), pick_extreme(), $urandom_range(0, DIM_MASK),
                  $urandom_range(0, DIM_MASK), 1'($urandom), $urandom_range(0, 127));
        repeat (12) offer_random_pixel();
      end else if (pick < 5) begin
        // normal mode: walk rows with width 1 up to the caption window,
        // widen the frame over the window, then finish narrow again
        h  = $urandom_range(49, 56);
        ch = $urandom_range(0, (h - 49 < 4) ? h - 49 : 4);
        w  = $urandom_range(25, 30);
        cw = $urandom_range(0, w);
        top = (h - ch - 2 * int'(PAD_NORMAL)) + int'(PAD_NORMAL);
        set_frame(1, h, cw, ch, 1'b0, pick_percent());
        while (!(col_pos == 0 && row_pos == top - 1)) offer_random_pixel();
        drain_pipe();
        write_register(REG_IMAGE_WIDTH, 12'(w));
        repeat ((ch + 2) * w) offer_random_pixel();
        drain_pipe();
        write_register(REG_IMAGE_WIDTH, 12'd1);
        finish_frame();
      end else begin
        // preview mode: whole small frames
        w  = $urandom_range(7, 16);
        h  = $urandom_range(1, 16);
        cw = $urandom_range(0, w + 3);
        ch = (h > 12) ? $urandom_range(0, h - 12) : $urandom_range(0, 3);
        set_frame(w, h, cw, ch, 1'b1, pick_percent());
        // long receiver hold once the frame is streaming
        if (phase == 1) long_hold = HOLD_LONG;
        if (!(col_pos == 0 && row_pos == 0)) finish_frame();
        finish_frame();
      end
      phase++;
    end

    // drain and settle
    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (expected_pixels.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (expected_pixels.size() != 0) begin
      $display("%0t ns: %0d requests never produced an output pixel", $time,
               expected_pixels.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("tb_caption_band_overlay_compositor passed");
    end else begin
      $display("tb_caption_band_overlay_compositor failed");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #3_000_000;
    $display("tb_caption_band_overlay_compositor failed");
    $finish;
  end

endmodule

>>> sim.f
rtl/cbo_pkg.sv
rtl/cbo_geometry.sv
rtl/cbo_compose.sv
rtl/caption_band_overlay_compositor.sv
rtl/cbo_checker.sv
tb/tb_caption_band_overlay_compositor.sv
